// File: design/rle8d_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the RLE8 bitmap decoder.
// No dependencies; used by every module of the block.
package rle8d_pkg;

    localparam int DEF_MAX_WIDTH       = 4096;
    localparam int DEF_MAX_HEIGHT      = 4096;
    localparam int DEF_PALETTE_ENTRIES = 256;
    localparam int DEF_MAX_FRAME_BYTES = 16777216;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_W      = 13;
    localparam int CFG_ADDR_W = 1;
    localparam int POS_W      = 16;
    localparam int BYTES_W    = 25;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 64;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd320;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd240;

    // Escape pair codes: a zero count byte, then the escape kind.
    localparam logic [7:0] ESC_PREFIX = 8'd0;
    localparam logic [7:0] ESC_EOL    = 8'd0;
    localparam logic [7:0] ESC_EOB    = 8'd1;
    localparam logic [7:0] ESC_DELTA  = 8'd2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_PAL   = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    // One queued command from the parser to the pixel back end.
    typedef struct packed {
        logic             is_pal;  // palette write, else pixel/done command
        logic [7:0]       want;    // requested pixels, 0 for a bare frame end
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [7:0]       cidx;    // palette index to read or slot to write
        logic [31:0]      color;   // palette write data
        logic             done;
    } t_cmd;

    function automatic logic [POS_W-1:0] sat16(input logic [POS_W-1:0] a,
                                               input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
    endfunction

endpackage

// File: design/rle8d_front.sv
`timescale 1ns / 1ps
// Parser front end: accepts input transfers, tracks the RLE8 byte phase
// and pushes palette and pixel commands into the queue. Uses rle8d_pkg.
module rle8d_front #(
    parameter int MAX_FRAME_BYTES = rle8d_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [1:0]                    i_op,
    input  logic [7:0]                    i_byte,
    input  logic [7:0]                    i_slot,
    input  logic [31:0]                   i_pcolor,
    input  logic [rle8d_pkg::BYTES_W-1:0] i_nbytes,
    input  logic                          i_q_full,
    output logic                          o_ready,
    output logic                          o_push,
    output rle8d_pkg::t_cmd               o_cmd
);
    import rle8d_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_COUNT = 7'b0000010,
        PH_VALUE = 7'b0000100,
        PH_DX    = 7'b0001000,
        PH_DY    = 7'b0010000,
        PH_LIT   = 7'b0100000,
        PH_PAD   = 7'b1000000
    } t_phase;

    localparam logic [BYTES_W-1:0] FRAME_CAP = BYTES_W'(MAX_FRAME_BYTES);

    t_phase             r_phase, n_phase;
    logic [7:0]         r_held, n_held;
    logic [7:0]         r_lit, n_lit;
    logic               r_pad, n_pad;
    logic [POS_W-1:0]   r_col, n_col;
    logic [POS_W-1:0]   r_row, n_row;
    logic [BYTES_W-1:0] r_bl, n_bl;

    logic acc, boundary, done;

    assign o_ready = !i_q_full;
    assign acc     = i_valid && !i_q_full;

    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_lit    = r_lit;
        n_pad    = r_pad;
        n_col    = r_col;
        n_row    = r_row;
        n_bl     = r_bl;
        boundary = 1'b0;
        done     = 1'b0;
        o_push   = 1'b0;
        o_cmd.is_pal = 1'b0;
        o_cmd.want   = 8'd0;
        o_cmd.col    = r_col;
        o_cmd.row    = r_row;
        o_cmd.cidx   = i_byte;
        o_cmd.color  = i_pcolor;
        o_cmd.done   = 1'b0;
        if (acc) begin
            case (i_op)
                OP_PAL: begin
                    o_push       = 1'b1;
                    o_cmd.is_pal = 1'b1;
                    o_cmd.cidx   = i_slot;
                end
                OP_START: begin
                    n_bl     = (i_nbytes > FRAME_CAP) ? FRAME_CAP : i_nbytes;
                    n_col    = '0;
                    n_row    = '0;
                    n_held   = '0;
                    n_lit    = '0;
                    n_pad    = 1'b0;
                    n_phase  = PH_COUNT;
                    boundary = 1'b1;
                end
                OP_DATA: begin
                    if (r_phase != PH_IDLE) begin
                        if (r_bl != '0) n_bl = r_bl - BYTES_W'(1);
                        unique case (r_phase)
                            PH_COUNT: begin
                                n_held  = i_byte;
                                n_phase = PH_VALUE;
                            end
                            PH_VALUE: begin
                                if (r_held != ESC_PREFIX) begin
                                    o_cmd.want = r_held;
                                    n_col      = sat16(r_col, {8'd0, r_held});
                                    n_phase    = PH_COUNT;
                                    boundary   = 1'b1;
                                end else if (i_byte == ESC_EOL) begin
                                    n_col    = '0;
                                    n_row    = sat16(r_row, 16'd1);
                                    n_phase  = PH_COUNT;
                                    boundary = 1'b1;
                                end else if (i_byte == ESC_EOB) begin
                                    done = 1'b1;
                                end else if (i_byte == ESC_DELTA) begin
                                    if (n_bl < BYTES_W'(2)) done = 1'b1;
                                    else n_phase = PH_DX;
                                end else begin
                                    // absolute block
                                    if (n_bl < {17'd0, i_byte}) begin
                                        done = 1'b1;
                                    end else begin
                                        n_lit   = i_byte;
                                        n_pad   = i_byte[0];
                                        n_phase = PH_LIT;
                                    end
                                end
                            end
                            PH_DX: begin
                                n_col   = sat16(r_col, {8'd0, i_byte});
                                n_phase = PH_DY;
                            end
                            PH_DY: begin
                                n_row    = sat16(r_row, {8'd0, i_byte});
                                n_phase  = PH_COUNT;
                                boundary = 1'b1;
                            end
                            PH_LIT: begin
                                o_cmd.want = 8'd1;
                                n_col      = sat16(r_col, 16'd1);
                                if (r_lit != 8'd0) n_lit = r_lit - 8'd1;
                                if (n_lit == 8'd0) begin
                                    if (r_pad) begin
                                        if (n_bl == '0) done = 1'b1;
                                        else n_phase = PH_PAD;
                                    end else begin
                                        n_phase  = PH_COUNT;
                                        boundary = 1'b1;
                                    end
                                end
                            end
                            PH_PAD: begin
                                n_pad    = 1'b0;
                                n_phase  = PH_COUNT;
                                boundary = 1'b1;
                            end
                            default: begin
                                n_phase = PH_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
            if (boundary && (n_bl < BYTES_W'(2))) done = 1'b1;
            if (done) n_phase = PH_IDLE;
            o_cmd.done = done;
            if (!o_cmd.is_pal && (o_cmd.want != 8'd0 || done)) o_push = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
            r_lit   <= '0;
            r_pad   <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
            r_bl    <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_lit   <= n_lit;
            r_pad   <= n_pad;
            r_col   <= n_col;
            r_row   <= n_row;
            r_bl    <= n_bl;
        end
    end

endmodule

// File: design/rle8d_queue.sv
`timescale 1ns / 1ps
// Short command queue between the parser and the pixel back end.
// Uses rle8d_pkg for the command type and depth.
module rle8d_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rle8d_pkg::t_cmd i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output rle8d_pkg::t_cmd o_cmd
);
    import rle8d_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp  = (r_wp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTR_W'(1);
            n_cnt = n_cnt + CNT_W'(1);
        end
        if (i_pop) begin
            n_rp  = (r_rp == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTR_W'(1);
            n_cnt = n_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: design/rle8d_back.sv
`timescale 1ns / 1ps
// Pixel back end: palette memory, row clipping, frame buffer address
// multiply and the output register. Uses rle8d_pkg.
module rle8d_back #(
    parameter int MAX_WIDTH       = rle8d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = rle8d_pkg::DEF_MAX_HEIGHT,
    parameter int PALETTE_ENTRIES = rle8d_pkg::DEF_PALETTE_ENTRIES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rle8d_pkg::CFG_W-1:0] i_width,
    input  logic [rle8d_pkg::CFG_W-1:0] i_height,
    input  logic                        i_q_valid,
    input  rle8d_pkg::t_cmd             i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [23:0]                 o_index,
    output logic [7:0]                  o_len,
    output logic [31:0]                 o_color,
    output logic                        o_done
);
    import rle8d_pkg::*;

    localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

    logic [31:0] r_pal [PALETTE_ENTRIES];
    logic [31:0] r_rd;

    logic [CFG_W-1:0] w_eff, h_eff, room, hm;
    logic [2*CFG_W-1:0] prod;
    logic [23:0] idx_c;
    logic [7:0]  len_c;
    logic        o_adv, a_ready;

    logic        r_a_valid;
    logic [7:0]  r_a_len;
    logic [23:0] r_a_idx;
    logic        r_a_done;

    assign w_eff = ({19'd0, i_width} > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : i_width;
    assign h_eff = ({19'd0, i_height} > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : i_height;

    assign o_adv   = !o_valid || i_ready;
    assign a_ready = !r_a_valid || o_adv;
    assign o_q_pop = i_q_valid && a_ready;

    // Clip against the row; the address only matters when something is written.
    always_comb begin
        room  = w_eff - i_q_cmd.col[CFG_W-1:0];
        hm    = h_eff - CFG_W'(1) - i_q_cmd.row[CFG_W-1:0];
        prod  = hm * w_eff;
        idx_c = prod[23:0] + {11'd0, i_q_cmd.col[CFG_W-1:0]};
        if ((i_q_cmd.row >= {3'd0, h_eff}) || (i_q_cmd.col >= {3'd0, w_eff})) begin
            len_c = 8'd0;
        end else if ({5'd0, i_q_cmd.want} < room) begin
            len_c = i_q_cmd.want;
        end else begin
            len_c = room[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            if (i_q_cmd.is_pal) r_pal[i_q_cmd.cidx[PAL_AW-1:0]] <= i_q_cmd.color;
            else r_rd <= r_pal[i_q_cmd.cidx[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready) begin
            r_a_len  <= len_c;
            r_a_idx  <= idx_c;
            r_a_done <= i_q_cmd.done;
        end
        if (o_adv) begin
            o_len   <= r_a_len;
            o_done  <= r_a_done;
            o_index <= (r_a_len != 8'd0) ? r_a_idx : 24'd0;
            o_color <= (r_a_len != 8'd0) ? r_rd : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= o_q_pop && !i_q_cmd.is_pal
                             && ((len_c != 8'd0) || i_q_cmd.done);
            end
            if (o_adv) o_valid <= r_a_valid;
        end
    end

endmodule

// File: design/rle8_bitmap_decoder.sv
`timescale 1ns / 1ps
// Top level of the RLE8 bitmap decoder: config registers, parser, queue
// and pixel back end. Depends on rle8d_pkg, rle8d_front/queue/back.
//
//  channel  dir  handshake              contents
//  s        in   i_s_tvalid/o_s_tready  tuser opcode, tdata byte/palette/count
//  m        out  o_m_tvalid/i_m_tready  tdata index/length/colour, tlast done
//  cfg      in   i_cfg_we               frame_width, frame_height
//
// One input transfer per cycle while the queue is not full; the parser phase is registered.
// A result passes through the queue, then the palette read plus address multiply
// stage, then the output register. Reset is synchronous
// and clears control state only; the palette holds garbage until written.
// A stalled output fills the four-entry queue before o_s_tready drops.
module rle8_bitmap_decoder #(
    parameter int MAX_WIDTH       = rle8d_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = rle8d_pkg::DEF_MAX_HEIGHT,
    parameter int PALETTE_ENTRIES = rle8d_pkg::DEF_PALETTE_ENTRIES,
    parameter int MAX_FRAME_BYTES = rle8d_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // code_byte[7:0], palette_slot[15:8], palette_color[47:16],
    // frame_bytes[72:48], zero fill [79:73]
    input  logic [rle8d_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // opcode[1:0]
    input  logic [rle8d_pkg::S_TUSER_W-1:0]  i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // pixel_index[23:0], run_length[31:24], pixel_color[63:32]
    output logic [rle8d_pkg::M_TDATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast,
    input  logic                             i_cfg_we,
    input  logic [rle8d_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rle8d_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import rle8d_pkg::*;

    logic [CFG_W-1:0] r_width, r_height;
    logic             q_full, q_valid, q_pop, push;
    t_cmd             push_cmd, q_cmd;
    logic [23:0]      out_index;
    logic [7:0]       out_len;
    logic [31:0]      out_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_FRAME_WIDTH:  r_width  <= i_cfg_wdata;
                REG_FRAME_HEIGHT: r_height <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    rle8d_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_op    (i_s_tuser[1:0]),
        .i_byte  (i_s_tdata[7:0]),
        .i_slot  (i_s_tdata[15:8]),
        .i_pcolor(i_s_tdata[47:16]),
        .i_nbytes(i_s_tdata[72:48]),
        .i_q_full(q_full),
        .o_ready (o_s_tready),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    rle8d_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_cmd  (q_cmd)
    );

    rle8d_back #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (r_width),
        .i_height (r_height),
        .i_q_valid(q_valid),
        .i_q_cmd  (q_cmd),
        .o_q_pop  (q_pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_index  (out_index),
        .o_len    (out_len),
        .o_color  (out_color),
        .o_done   (o_m_tlast)
    );

    assign o_m_tdata = {out_color, out_len, out_index};

endmodule

// File: design/rle8d_checker.sv
`timescale 1ns / 1ps
// Port-level checks for rle8_bitmap_decoder, bound to the top level.
// Depends on rle8d_pkg for port widths.
module rle8d_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [rle8d_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input logic                             o_m_tlast
);
    // Results never come out of reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // A result that writes nothing must be a frame end.
    a_empty_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[31:24] == 8'd0) |-> o_m_tlast)
        else $error("empty result without frame end");

    // With nothing written, index and colour read as zero.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[31:24] == 8'd0)
        |-> (o_m_tdata[23:0] == 24'd0 && o_m_tdata[63:32] == 32'd0))
        else $error("empty result carries index or colour");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("output valid dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("output payload changed while stalled");
endmodule

bind rle8_bitmap_decoder rle8d_checker u_rle8d_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tlast (o_m_tlast)
);
